/* sv/tlpp_pkg.sv */
`timescale 1ns / 1ps

package tlpp_pkg;

  localparam int STATES  = 16;
  localparam int STATE_W = 4;
  localparam int COLUMNS = 64;
  localparam int COL_W   = 6;
  localparam int WGT_W   = 17;
  localparam int ROW_AW  = COL_W + STATE_W;
  localparam int ROWS    = COLUMNS * STATES;
  localparam int PG_W    = 2 * WGT_W;

  localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

  localparam logic REG_LEARN_RATE = 1'b0;
  localparam logic REG_DISCOUNT   = 1'b1;

  typedef logic [STATES-1:0][WGT_W-1:0] row_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic lrd;
    logic lmul;
    logic lwr;
    logic sinit;
    logic ssel;
    logic smul;
    logic salt;
    logic supd;
    logic outload;
    logic which;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic learn;
    logic goal_hit;
  } sts_t;

endpackage

/* sv/tlpp_ctrl.sv */
`timescale 1ns / 1ps

module tlpp_ctrl
  import tlpp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LRD   = 4'd2;
  localparam logic [3:0] S_LMUL  = 4'd3;
  localparam logic [3:0] S_LWR   = 4'd4;
  localparam logic [3:0] S_SINIT = 4'd5;
  localparam logic [3:0] S_SSEL  = 4'd6;
  localparam logic [3:0] S_SMUL  = 4'd7;
  localparam logic [3:0] S_SALT  = 4'd8;
  localparam logic [3:0] S_SUPD  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state, state_next;
  logic       which, which_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    which_next = which;
    cmd = '0;
    cmd.which = which;
    unique case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_LRD;
        end
      end
      S_LRD: begin
        cmd.lrd = 1'b1;
        state_next = sts.learn ? S_LMUL : S_SINIT;
      end
      S_LMUL: begin
        cmd.lmul = 1'b1;
        state_next = S_LWR;
      end
      S_LWR: begin
        cmd.lwr = 1'b1;
        state_next = S_SINIT;
      end
      S_SINIT: begin
        cmd.sinit = 1'b1;
        state_next = S_SSEL;
      end
      S_SSEL: begin
        cmd.ssel = 1'b1;
        if (sts.goal_hit) begin
          if (!which) begin
            which_next = 1'b1;
            state_next = S_SINIT;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_SMUL;
        end
      end
      S_SMUL: begin
        cmd.smul = 1'b1;
        state_next = S_SALT;
      end
      S_SALT: begin
        cmd.salt = 1'b1;
        state_next = S_SUPD;
      end
      S_SUPD: begin
        cmd.supd = 1'b1;
        state_next = S_SSEL;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.outload = 1'b1;
          which_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      which <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      which <= which_next;
      out_valid <= cmd.outload | (out_valid & out_stall);
    end
  end

endmodule

/* sv/tlpp_dp.sv */
`timescale 1ns / 1ps

module tlpp_dp
  import tlpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [WGT_W-1:0]   cfg_wdata,
  input  logic [COL_W-1:0]   column,
  input  logic [STATE_W-1:0] current_state,
  input  logic [STATE_W-1:0] previous_state,
  input  logic [STATE_W-1:0] feedback_goal,
  input  logic [STATE_W-1:0] local_goal,
  input  logic               learn,
  output logic [STATE_W-1:0] predicted_state
);

  logic [WGT_W-1:0] learn_rate, discount, rate, gam;

  logic [COL_W-1:0]   col_r;
  logic [STATE_W-1:0] cur_r, prv_r, fg_r, lg_r;
  logic               learn_r;

  row_t               wmem [ROWS];
  logic [STATE_W-1:0] lpmem [COLUMNS];
  row_t               rrow;
  logic [STATE_W-1:0] lp_q;
  logic [ROW_AW-1:0]  clr_cnt;

  logic               w_we;
  logic [ROW_AW-1:0]  w_waddr, w_raddr;
  row_t               w_wdata, row_n;
  logic               w_re;
  logic               lp_we;
  logic [COL_W-1:0]   lp_waddr;
  logic [STATE_W-1:0] lp_wdata;

  logic [WGT_W-1:0]   d0, d1;
  logic [STATE_W-1:0] old_r;
  logic [PG_W-1:0]    prod0, prod1, sum0, sum1;

  logic [WGT_W-1:0]   p     [STATES];
  logic               done  [STATES];
  logic               hp    [STATES];
  logic [STATE_W-1:0] first [STATES];
  logic [WGT_W-1:0]   alt   [STATES];
  logic [WGT_W-1:0]   alt_n [STATES];
  logic [51:0]        aprod [STATES];
  logic [STATE_W-1:0] u_r;
  logic [PG_W-1:0]    pg;

  logic               tv [STATE_W+1][STATES];
  logic [WGT_W-1:0]   tp [STATE_W+1][STATES];
  logic [STATE_W-1:0] ti [STATE_W+1][STATES];
  logic [STATE_W-1:0] sel_i, goal, sel_step;

  logic [WGT_W-1:0]   fprob, lprob;
  logic [STATE_W-1:0] fstep, lstep, pick;

  assign rate = (learn_rate > ONE_Q16) ? ONE_Q16 : learn_rate;
  assign gam  = (discount > ONE_Q16) ? ONE_Q16 : discount;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= WGT_W'(6554);
      discount <= WGT_W'(64881);
      clr_cnt <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEARN_RATE: learn_rate <= cfg_wdata;
          REG_DISCOUNT:   discount <= cfg_wdata;
        endcase
      end
      if (cmd.clr) clr_cnt <= clr_cnt + ROW_AW'(1);
    end
  end

  assign sts.clr_last = (clr_cnt == ROW_AW'(ROWS - 1));
  assign sts.learn = learn_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= column;
      cur_r <= current_state;
      prv_r <= previous_state;
      fg_r <= feedback_goal;
      lg_r <= local_goal;
      learn_r <= learn;
    end
  end

  always_comb begin
    row_n = rrow;
    if (old_r != cur_r) row_n[old_r] = rrow[old_r] - d0;
    row_n[cur_r] = rrow[cur_r] + d1;
  end

  assign w_we    = cmd.clr | cmd.lwr;
  assign w_waddr = cmd.clr ? clr_cnt : {col_r, prv_r};
  assign w_wdata = cmd.clr ? '0 : row_n;
  assign w_re    = cmd.lrd | cmd.ssel;
  assign w_raddr = cmd.ssel ? {col_r, sel_i} : {col_r, prv_r};

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    if (w_re) rrow <= wmem[w_raddr];
  end

  assign lp_we    = cmd.clr | cmd.outload;
  assign lp_waddr = cmd.clr ? clr_cnt[COL_W-1:0] : col_r;
  assign lp_wdata = cmd.clr ? '0 : pick;

  always_ff @(posedge clk) begin
    if (lp_we) lpmem[lp_waddr] <= lp_wdata;
    if (cmd.lrd) lp_q <= lpmem[col_r];
  end

  always_comb begin
    prod0 = PG_W'(rate) * PG_W'(rrow[lp_q]);
    prod1 = PG_W'(rate) * PG_W'(ONE_Q16 - rrow[cur_r]);
    sum0 = prod0 + PG_W'(32768);
    sum1 = prod1 + PG_W'(32768);
  end

  always_ff @(posedge clk) begin
    if (cmd.lmul) begin
      d0 <= sum0[WGT_W+15:16];
      d1 <= sum1[WGT_W+15:16];
      old_r <= lp_q;
    end
  end

  always_comb begin
    for (int i = 0; i < STATES; i++) begin
      tv[0][i] = !done[i];
      tp[0][i] = p[i];
      ti[0][i] = STATE_W'(i);
    end
    for (int l = 0; l < STATE_W; l++) begin
      for (int k = 0; k < STATES; k++) begin
        tv[l+1][k] = 1'b0;
        tp[l+1][k] = '0;
        ti[l+1][k] = '0;
      end
      for (int k = 0; k < (STATES >> (l + 1)); k++) begin
        if (tv[l][2*k+1] && (!tv[l][2*k] || tp[l][2*k+1] > tp[l][2*k])) begin
          tv[l+1][k] = tv[l][2*k+1];
          tp[l+1][k] = tp[l][2*k+1];
          ti[l+1][k] = ti[l][2*k+1];
        end else begin
          tv[l+1][k] = tv[l][2*k];
          tp[l+1][k] = tp[l][2*k];
          ti[l+1][k] = ti[l][2*k];
        end
      end
    end
    sel_i = ti[STATE_W][0];
  end

  assign goal = cmd.which ? lg_r : fg_r;
  assign sts.goal_hit = tv[STATE_W][0] && (sel_i == goal);
  assign sel_step = hp[sel_i] ? first[sel_i] : sel_i;

  always_comb begin
    for (int i = 0; i < STATES; i++) begin
      aprod[i] = 52'(pg) * 52'(rrow[i]) + 52'h0_0000_8000_0000;
      alt_n[i] = aprod[i][WGT_W+31:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sinit) begin
      for (int i = 0; i < STATES; i++) begin
        p[i] <= (STATE_W'(i) == cur_r) ? ONE_Q16 : '0;
        done[i] <= 1'b0;
        hp[i] <= 1'b0;
      end
    end
    if (cmd.ssel) begin
      if (sts.goal_hit) begin
        if (cmd.which) begin
          lprob <= p[sel_i];
          lstep <= sel_step;
        end else begin
          fprob <= p[sel_i];
          fstep <= sel_step;
        end
      end else begin
        done[sel_i] <= 1'b1;
        u_r <= sel_i;
      end
    end
    if (cmd.smul) pg <= PG_W'(p[u_r]) * PG_W'(gam);
    if (cmd.salt) begin
      for (int i = 0; i < STATES; i++) alt[i] <= alt_n[i];
    end
    if (cmd.supd) begin
      for (int i = 0; i < STATES; i++) begin
        if (!done[i] && alt[i] > p[i]) begin
          p[i] <= alt[i];
          hp[i] <= 1'b1;
          first[i] <= (u_r == cur_r) ? STATE_W'(i) : first[u_r];
        end
      end
    end
    if (cmd.outload) predicted_state <= pick;
  end

  assign pick = (fprob > lprob) ? fstep : lstep;

endmodule

/* sv/transition_learn_and_path_predict_core.sv */
`timescale 1ns / 1ps

// Transition learner and path predictor. Each column keeps a 16 by 16 table of Q1.16
// transition weights and its last prediction. An accepted beat optionally updates the
// weights, then runs two max-product searches from current_state, one toward each goal,
// and returns the first step of the more probable path (local goal on ties). After reset
// the block clears its weight memory one row a cycle, and its stored predictions alongside,
// with in_stall high. An item passes through accept, a read of the weight row and last
// prediction, a multiply and write-back when learning, then per search one setup step plus,
// per visited state, select, weight row read and discount multiply, 16 parallel lane
// multiplies and relax, and one final select; the result is then handed off once the
// output is free. Configuration writes take effect at once and belong in idle time.

module transition_learn_and_path_predict_core
  import tlpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [WGT_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COL_W-1:0]   column,
  input  logic [STATE_W-1:0] current_state,
  input  logic [STATE_W-1:0] previous_state,
  input  logic [STATE_W-1:0] feedback_goal,
  input  logic [STATE_W-1:0] local_goal,
  input  logic               learn,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STATE_W-1:0] predicted_state
);

  cmd_t cmd;
  sts_t sts;

  tlpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlpp_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .column          (column),
    .current_state   (current_state),
    .previous_state  (previous_state),
    .feedback_goal   (feedback_goal),
    .local_goal      (local_goal),
    .learn           (learn),
    .predicted_state (predicted_state)
  );

endmodule
